### rtl/core/swpt_pkg.sv
// Shared types and constants for the sliding-window 95th-percentile tracker.
package swpt_pkg;

    localparam int WINDOW_DEFAULT = 512;
    localparam int VAL_W          = 31;
    localparam int COUNT_OUT_W    = 10;

    // floor(n/20) == (n * 3277) >> 16 for every n below 16384
    localparam int DIV20_MUL      = 3277;
    localparam int DIV20_SHIFT    = 16;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANK,
        ST_SCAN,
        ST_TALLY
    } state_t;

endpackage

### rtl/core/swpt_ram.sv
// Sample ring storage: one write port, one registered read port.
module swpt_ram #(
    parameter int DEPTH = swpt_pkg::WINDOW_DEFAULT,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [swpt_pkg::VAL_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [swpt_pkg::VAL_W-1:0] rd_data
);

    logic [swpt_pkg::VAL_W-1:0] mem [DEPTH];
    logic [swpt_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/sliding_window_p95_tracker_top.sv
// Top level: ring of recent samples with a radix-select 95th-percentile query.
// Record, clear and unused-mode items finish in idle; the result is registered at the accept edge.
// A query on n held samples sets up its rank, then runs 31 bit passes, each a walk of the
// ring through its single read port followed by a tally decision. An empty window answers at once.
// Reset clears the count, oldest slot, FSM and output valid; ring contents stay undefined.
module sliding_window_p95_tracker_top #(
    parameter int WINDOW = swpt_pkg::WINDOW_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       mode,
    input  logic signed [31:0]               sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             accepted,
    output logic [swpt_pkg::VAL_W-1:0]       percentile_value,
    output logic [swpt_pkg::COUNT_OUT_W-1:0] sample_count
);

    localparam int AW    = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int VW    = swpt_pkg::VAL_W;
    localparam int OW    = swpt_pkg::COUNT_OUT_W;
    localparam int PW    = CNT_W + swpt_pkg::DIV20_SHIFT + 1;

    swpt_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    oldest_reg, oldest_next;

    logic             out_valid_reg, out_valid_next;
    logic             accepted_reg, accepted_next;
    logic [VW-1:0]    pval_reg, pval_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    logic [VW-1:0]    prefix_reg, prefix_next;
    logic [VW-1:0]    hi_mask_reg, hi_mask_next;
    logic [VW-1:0]    bit_sel_reg, bit_sel_next;
    logic [CNT_W-1:0] rank_reg, rank_next;
    logic [CNT_W-1:0] tally_reg, tally_next;
    logic [AW-1:0]    scan_addr_reg, scan_addr_next;
    logic             rd_valid_reg, rd_valid_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VW-1:0]    rd_data;

    logic             out_free;
    logic             in_take;
    logic             full;
    logic             hit;
    logic             scan_last;
    logic [CNT_W-1:0] tally_sum;
    logic [PW-1:0]    div_prod;
    logic [CNT_W-1:0] div_q;
    logic [CNT_W+OW-1:0] count_ext;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == swpt_pkg::ST_IDLE) && out_free);
    assign in_take   = in_valid && !in_stall;
    assign full      = (count_reg == CNT_W'(WINDOW));

    // element still matches the prefix above the current bit and has a 0 there
    assign hit = rd_valid_reg
              && (((rd_data ^ prefix_reg) & hi_mask_reg) == '0)
              && ((rd_data & bit_sel_reg) == '0);
    assign tally_sum = tally_reg + CNT_W'(hit);
    assign scan_last = ((CNT_W'(scan_addr_reg) + CNT_W'(1)) == count_reg);

    assign div_prod = PW'(count_reg) * PW'(swpt_pkg::DIV20_MUL);
    assign div_q    = div_prod[CNT_W+swpt_pkg::DIV20_SHIFT-1:swpt_pkg::DIV20_SHIFT];

    assign wr_en   = in_take && (mode == swpt_pkg::MODE_RECORD) && !sample[31];
    assign wr_addr = full ? oldest_reg : count_reg[AW-1:0];

    swpt_ram #(
        .DEPTH (WINDOW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sample[VW-1:0]),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swpt_pkg::ST_IDLE:
            begin
                if (in_take && (mode == swpt_pkg::MODE_QUERY) && (count_reg != '0))
                begin
                    state_next = swpt_pkg::ST_RANK;
                end
            end
            swpt_pkg::ST_RANK:
            begin
                state_next = swpt_pkg::ST_SCAN;
            end
            swpt_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = swpt_pkg::ST_TALLY;
                end
            end
            swpt_pkg::ST_TALLY:
            begin
                state_next = bit_sel_reg[0] ? swpt_pkg::ST_IDLE : swpt_pkg::ST_SCAN;
            end
            default:
            begin
                state_next = swpt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        out_valid_next = out_valid_reg && out_stall;
        accepted_next  = accepted_reg;
        pval_next      = pval_reg;
        out_count_next = out_count_reg;
        prefix_next    = prefix_reg;
        hi_mask_next   = hi_mask_reg;
        bit_sel_next   = bit_sel_reg;
        rank_next      = rank_reg;
        tally_next     = tally_reg;
        scan_addr_next = scan_addr_reg;
        rd_valid_next  = 1'b0;

        case (state_reg)
            swpt_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    accepted_next  = 1'b0;
                    pval_next      = '0;
                    out_count_next = count_reg;
                    out_valid_next = 1'b1;
                    case (mode)
                        swpt_pkg::MODE_RECORD:
                        begin
                            if (!sample[31])
                            begin
                                accepted_next = 1'b1;
                                if (full)
                                begin
                                    oldest_next = (oldest_reg == AW'(WINDOW - 1))
                                                ? '0 : oldest_reg + AW'(1);
                                end
                                else
                                begin
                                    count_next     = count_reg + CNT_W'(1);
                                    out_count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        swpt_pkg::MODE_QUERY:
                        begin
                            // non-empty window: result comes from the select walk
                            if (count_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                            end
                        end
                        swpt_pkg::MODE_CLEAR:
                        begin
                            count_next     = '0;
                            oldest_next    = '0;
                            out_count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            swpt_pkg::ST_RANK:
            begin
                // rank = ceil(19n/20) - 1 = n - floor(n/20) - 1
                rank_next      = count_reg - div_q - CNT_W'(1);
                prefix_next    = '0;
                hi_mask_next   = '0;
                bit_sel_next   = {1'b1, {(VW-1){1'b0}}};
                tally_next     = '0;
                scan_addr_next = '0;
            end
            swpt_pkg::ST_SCAN:
            begin
                tally_next     = tally_sum;
                rd_valid_next  = 1'b1;
                scan_addr_next = scan_addr_reg + AW'(1);
            end
            swpt_pkg::ST_TALLY:
            begin
                if (rank_reg >= tally_sum)
                begin
                    prefix_next = prefix_reg | bit_sel_reg;
                    rank_next   = rank_reg - tally_sum;
                end
                hi_mask_next   = hi_mask_reg | bit_sel_reg;
                bit_sel_next   = bit_sel_reg >> 1;
                tally_next     = '0;
                scan_addr_next = '0;
                if (bit_sel_reg[0])
                begin
                    out_valid_next = 1'b1;
                    accepted_next  = 1'b0;
                    pval_next      = (rank_reg >= tally_sum)
                                   ? (prefix_reg | bit_sel_reg) : prefix_reg;
                    out_count_next = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swpt_pkg::ST_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg  <= accepted_next;
        pval_reg      <= pval_next;
        out_count_reg <= out_count_next;
        prefix_reg    <= prefix_next;
        hi_mask_reg   <= hi_mask_next;
        bit_sel_reg   <= bit_sel_next;
        rank_reg      <= rank_next;
        tally_reg     <= tally_next;
        scan_addr_reg <= scan_addr_next;
    end

    assign count_ext = {{OW{1'b0}}, out_count_reg};

    assign out_valid        = out_valid_reg;
    assign accepted         = accepted_reg;
    assign percentile_value = pval_reg;
    assign sample_count     = count_ext[OW-1:0];

endmodule

### tb/sv/sliding_window_p95_tracker_checker.sv
// Checker for the 95th-percentile tracker: mirrors the sample window and checks each result item.
module sliding_window_p95_tracker_checker #(
    parameter int WINDOW = swpt_pkg::WINDOW_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [1:0]                       mode,
    input  logic signed [31:0]               sample,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             accepted,
    input  logic [swpt_pkg::VAL_W-1:0]       percentile_value,
    input  logic [swpt_pkg::COUNT_OUT_W-1:0] sample_count,
    output int                               fail_count,
    output int                               pending_count,
    output int                               result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                             stored;
        logic [swpt_pkg::VAL_W-1:0]       p95;
        logic [swpt_pkg::COUNT_OUT_W-1:0] count;
    } tracker_result_t;

    logic [swpt_pkg::VAL_W-1:0] window_mem [WINDOW];
    int unsigned                oldest;
    int unsigned                held;
    tracker_result_t            awaited_results [$];

    // sort a copy of the window, oldest first, and pick rank ceil(19n/20)-1
    function automatic logic [swpt_pkg::VAL_W-1:0] window_p95();
        logic [swpt_pkg::VAL_W-1:0] ordered [WINDOW];
        logic [swpt_pkg::VAL_W-1:0] v;
        int unsigned                n;
        int unsigned                i;
        int unsigned                j;
        int unsigned                rank;
        n = held;
        if (n == 0)
            return '0;
        for (i = 0; i < n; i++)
            ordered[i] = window_mem[(oldest + i) % WINDOW];
        for (i = 1; i < n; i++)
        begin
            v = ordered[i];
            j = i;
            while (j > 0 && ordered[j - 1] > v)
            begin
                ordered[j] = ordered[j - 1];
                j--;
            end
            ordered[j] = v;
        end
        rank = (19 * n + 19) / 20 - 1;
        if (rank > n - 1)
            rank = n - 1;
        return ordered[rank];
    endfunction

    function automatic tracker_result_t window_update(logic [1:0] m, logic [31:0] s);
        tracker_result_t r;
        r = '0;
        case (m)
            swpt_pkg::MODE_RECORD:
                if (!s[31])
                begin
                    if (held >= WINDOW)
                    begin
                        window_mem[oldest] = s[swpt_pkg::VAL_W-1:0];
                        oldest = (oldest + 1) % WINDOW;
                    end
                    else
                    begin
                        window_mem[(oldest + held) % WINDOW] = s[swpt_pkg::VAL_W-1:0];
                        held++;
                    end
                    r.stored = 1'b1;
                end
            swpt_pkg::MODE_QUERY:
                r.p95 = window_p95();
            swpt_pkg::MODE_CLEAR:
            begin
                held = 0;
                oldest = 0;
            end
            default:
                ;
        endcase
        r.count = swpt_pkg::COUNT_OUT_W'(held);
        return r;
    endfunction

    // results are compared before the same edge's input item is folded in
    always @(posedge clk or negedge rst_n)
    begin : observe
        tracker_result_t seen;
        tracker_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            held = 0;
            oldest = 0;
            fail_count = 0;
            pending_count = 0;
            result_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen.stored = accepted;
                seen.p95 = percentile_value;
                seen.count = sample_count;
                result_count++;
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d with no item outstanding: accepted %0b pct %0d cnt %0d",
                                 result_count, seen.stored, seen.p95, seen.count);
                end
                else
                begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    if (seen.stored !== want.stored || seen.p95 !== want.p95
                        || seen.count !== want.count)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"result %0d wrong (got/exp): ",
                                      "accepted %0b/%0b pct %0d/%0d cnt %0d/%0d"},
                                     result_count, seen.stored, want.stored, seen.p95, want.p95,
                                     seen.count, want.count);
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_results = {awaited_results, window_update(mode, sample)};
            pending_count = awaited_results.size();
        end
    end

endmodule

### tb/sv/sliding_window_p95_tracker_top_tb.sv
// Testbench top for the 95th-percentile tracker: clock, reset, item stimulus and verdict.
module sliding_window_p95_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         WINDOW       = swpt_pkg::WINDOW_DEFAULT;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         ITEM_GOAL    = 2000;
    localparam int         FILL_SPAN    = 1200;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         IDLE_LIMIT   = 100000;
    localparam int         DRAIN_CYCLES = 20;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [1:0]                       mode;
    logic signed [31:0]               sample;
    logic                             out_valid;
    logic                             out_stall;
    logic                             accepted;
    logic [swpt_pkg::VAL_W-1:0]       percentile_value;
    logic [swpt_pkg::COUNT_OUT_W-1:0] sample_count;

    int fail_count;
    int pending_count;
    int result_count;

    bit          hold_request;
    bit          steady;
    int unsigned burst_left;
    int unsigned held;
    int unsigned idle_cycles = 0;
    int unsigned n_items;
    int unsigned n_records;
    int unsigned n_overwrites;
    int unsigned n_dropped;
    int unsigned n_queries;
    int unsigned n_full_queries;
    int unsigned n_clears;
    int unsigned n_unused;

    sliding_window_p95_tracker_top #(
        .WINDOW(WINDOW)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (accepted),
        .percentile_value (percentile_value),
        .sample_count     (sample_count)
    );

    sliding_window_p95_tracker_checker #(
        .WINDOW(WINDOW)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (accepted),
        .percentile_value (percentile_value),
        .sample_count     (sample_count),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .result_count     (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly small values so the window holds duplicates; some full range and extremes
    function automatic logic [31:0] timing_sample();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2: w = {1'b0, 31'($urandom_range(0, 1000))};
            3, 4:    w = {1'b0, 31'($urandom_range(0, 200000))};
            5, 6:    w[31] = 1'b0;
            7:       w = {1'b0, ($urandom_range(0, 1) != 0) ? 31'h7FFF_FFFF : 31'h0};
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_item(input logic [1:0] m, input logic [31:0] s);
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    repeat ($urandom_range(1, 6))
                    begin
                        @(negedge clk);
                        in_valid <= 1'b0;
                    end
            end
            burst_left--;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode <= m;
        sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        n_items++;
        case (m)
            swpt_pkg::MODE_RECORD:
                if (s[31])
                    n_dropped++;
                else
                begin
                    n_records++;
                    if (held == WINDOW)
                        n_overwrites++;
                    else
                        held++;
                end
            swpt_pkg::MODE_QUERY:
            begin
                n_queries++;
                if (held == WINDOW)
                    n_full_queries++;
            end
            swpt_pkg::MODE_CLEAR:
            begin
                n_clears++;
                held = 0;
            end
            default:
                n_unused++;
        endcase
    endtask

    // count record offers, with queries and ignored items mixed in
    task automatic record_run(input int unsigned count, input int unsigned query_pct);
        int unsigned done;
        int unsigned roll;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < query_pct)
                send_item(swpt_pkg::MODE_QUERY, $urandom());
            else if (roll < query_pct + 4)
                send_item(swpt_pkg::MODE_RECORD, {1'b1, 31'($urandom())});
            else if (roll < query_pct + 6)
                send_item(MODE_UNUSED, $urandom());
            else
            begin
                send_item(swpt_pkg::MODE_RECORD, timing_sample());
                done++;
            end
        end
    endtask

    initial
    begin : receiver
        stall_style_t style;
        int unsigned  style_left;
        int unsigned  hold_left;
        int unsigned  tick;
        out_stall = 1'b0;
        style = STALL_NONE;
        style_left = 0;
        hold_left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = stall_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(20, 300);
                end
                style_left--;
                case (style)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
                    default:     out_stall <= (tick % 5 < 2);
                endcase
            end
        end
    end

    // a full-window query runs long with no handshake; the limit is well above its length
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: %0d cycles without a handshake", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned episode;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = swpt_pkg::MODE_RECORD;
        sample = '0;
        hold_request = 1'b0;
        steady = 1'b1;
        burst_left = 0;
        held = 0;
        episode = 0;
        n_items = 0;
        n_records = 0;
        n_overwrites = 0;
        n_dropped = 0;
        n_queries = 0;
        n_full_queries = 0;
        n_clears = 0;
        n_unused = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty window, extremes, negatives, unused mode, duplicates, clear
        send_item(swpt_pkg::MODE_QUERY, 32'h0);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF);
        send_item(swpt_pkg::MODE_CLEAR, 32'h0);
        send_item(swpt_pkg::MODE_RECORD, 32'h0000_0000);
        send_item(swpt_pkg::MODE_RECORD, 32'h7FFF_FFFF);
        send_item(swpt_pkg::MODE_RECORD, 32'h8000_0000);
        send_item(swpt_pkg::MODE_RECORD, 32'hFFFF_FFFF);
        send_item(swpt_pkg::MODE_QUERY, 32'hFFFF_FFFF);
        send_item(swpt_pkg::MODE_RECORD, 32'h5555_5555);
        send_item(swpt_pkg::MODE_RECORD, 32'hAAAA_AAAA);
        send_item(swpt_pkg::MODE_RECORD, 32'h2AAA_AAAA);
        send_item(swpt_pkg::MODE_QUERY, 32'h0);
        send_item(MODE_UNUSED, 32'h1234_5678);
        send_item(swpt_pkg::MODE_RECORD, 32'h1);
        send_item(swpt_pkg::MODE_RECORD, 32'h1);
        send_item(swpt_pkg::MODE_QUERY, 32'h0);
        send_item(swpt_pkg::MODE_CLEAR, 32'hFFFF_FFFF);
        send_item(swpt_pkg::MODE_QUERY, 32'h0);
        send_item(swpt_pkg::MODE_RECORD, 32'h0);
        send_item(swpt_pkg::MODE_QUERY, 32'h0);
        send_item(swpt_pkg::MODE_CLEAR, 32'h0);

        // long receiver hold while records keep coming back to back
        hold_request = 1'b1;
        record_run(48, 0);
        send_item(swpt_pkg::MODE_QUERY, $urandom());
        steady = 1'b0;

        while (n_items < ITEM_GOAL)
        begin
            episode++;
            if (episode % 20 == 10 && n_items + FILL_SPAN < ITEM_GOAL)
            begin
                // fill to one short of full, then full, then overwrite past the oldest
                send_item(swpt_pkg::MODE_CLEAR, $urandom());
                record_run(WINDOW - 1, 0);
                while (held < WINDOW - 1)
                    send_item(swpt_pkg::MODE_RECORD, {1'b0, 31'($urandom_range(0, 5000))});
                send_item(swpt_pkg::MODE_QUERY, $urandom());
                while (held < WINDOW)
                    send_item(swpt_pkg::MODE_RECORD, {1'b0, 31'($urandom())});
                send_item(swpt_pkg::MODE_QUERY, $urandom());
                record_run($urandom_range(1, 600), 0);
                send_item(swpt_pkg::MODE_QUERY, $urandom());
            end
            else if (episode % 7 == 0)
            begin
                if (held > 200)
                    send_item(swpt_pkg::MODE_CLEAR, $urandom());
                record_run($urandom_range(60, 200), 0);
                send_item(swpt_pkg::MODE_QUERY, $urandom());
            end
            else
            begin
                if (held > 40 || $urandom_range(0, 3) == 0)
                    send_item(swpt_pkg::MODE_CLEAR, $urandom());
                record_run($urandom_range(1, 24), 10);
                send_item(swpt_pkg::MODE_QUERY, $urandom());
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d items: %0d stored samples (%0d replaced the oldest), %0d negative",
                 n_items, n_records, n_overwrites, n_dropped);
        $display("%0d mode 3, %0d percentile queries (%0d on a full window), %0d clears, %0d checked",
                 n_unused, n_queries, n_full_queries, n_clears, result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
